[rtl/core/lfuc_pkg.sv]
// Package for the LFU cache table: widths, register map, opcodes, sequencer states.
// No dependencies; lfuc_if and the top level import it.
`default_nettype none

package lfuc_pkg;

    // Build-time defaults for the top-level parameters
    localparam int ENTRIES_DEF    = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed payload widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 64;

    // Configuration port
    localparam int          APB_DW    = 32;
    localparam int          PADDR_W   = 2;
    localparam int          CAP_W     = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = '0;

    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

[rtl/core/lfuc_if.sv]
// Request and response channel interfaces of the LFU cache table.
// Depends on lfuc_pkg for the opcode type and payload widths.
`default_nettype none

interface lfuc_req_if;
    import lfuc_pkg::*;

    logic                    valid;
    logic                    ready;
    t_op                     op;
    logic signed [KEY_W-1:0] key;
    logic        [VAL_W-1:0] write_value;

    modport source (output valid, op, key, write_value, input ready);
    modport sink   (input valid, op, key, write_value, output ready);
endinterface

interface lfuc_rsp_if;
    import lfuc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic        [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

[rtl/core/lfuc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module lfuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/lfu_cache_table_unit.sv]
// LFU cache table top level: sequencer, scan compare unit, recency ranks, APB register.
// Depends on lfuc_pkg, lfuc_req_if / lfuc_rsp_if and lfuc_ram.
//
// Requests (get or set of a 32-bit key, 64-bit value on set) arrive on i_req, a
// valid/ready channel; exactly one response per request leaves on o_rsp. The store
// is fully associative, ENTRIES deep, least-frequently-used replacement, ties going
// to the least recently touched entry. Capacity is an APB register at byte address 0
// (reset 8, clamped to ENTRIES, zero turns every set into a no-op); write it only
// while no request is in flight.
//
// Sequence: after the accepting idle cycle, the scan reads one entry per cycle from
// the table RAM into a shared compare unit (key match, victim choice), running on
// past the last address to cover the registered read; the update state then writes
// the RAM, the valid bits, the ranks and the output register.
// i_req.ready is high only in the idle state. A finished response waits in the output
// register while the next request is taken; if the receiver still stalls it when the
// next update is due, the update cycle holds and nothing new is accepted.
//
// Reset (synchronous, active low): all entries invalid, ranks in index order,
// capacity 8, no response pending. Key/value/count RAM is not cleared.
`default_nettype none

module lfu_cache_table_unit #(
    parameter int ENTRIES    = lfuc_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    lfuc_req_if.sink                          i_req,
    lfuc_rsp_if.source                        o_rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lfuc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lfuc_pkg::APB_DW-1:0]  pwdata,
    output logic      [lfuc_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);
    import lfuc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMPW   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = KEY_W + VAL_W + COUNT_BITS;

    localparam logic [CNT_W-1:0]      SCAN_END  = CNT_W'(ENTRIES);
    localparam logic [CMPW-1:0]       ENT_LIMIT = CMPW'(ENTRIES);
    localparam logic [IDX_W-1:0]      RANK_TOP  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // ---------------- configuration register ----------------
    logic [CAP_W-1:0] r_capacity;

    assign pready = 1'b1;
    assign prdata = APB_DW'(r_capacity);

    // ---------------- request latch and sequencer ----------------
    t_state                   r_state, n_state;
    t_op                      r_op;
    logic signed [KEY_W-1:0]  r_key;
    logic        [VAL_W-1:0]  r_wval;
    logic        [CNT_W-1:0]  r_cnt;       // scan read address, runs to ENTRIES
    logic                     r_cmp_vld;   // RAM data on the read port is live
    logic        [IDX_W-1:0]  r_cmp_idx;

    logic in_ready;
    logic upd_fire;
    logic req_fire;

    // ---------------- per-entry state in flops ----------------
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [IDX_W-1:0]   r_rank [ENTRIES];   // higher = more recently touched

    // ---------------- scan results ----------------
    logic                    r_found;
    logic [IDX_W-1:0]        r_found_idx;
    logic [VAL_W-1:0]        r_found_val;
    logic [COUNT_BITS-1:0]   r_found_cnt;
    logic                    r_vic_found;
    logic [IDX_W-1:0]        r_vic_idx;
    logic signed [KEY_W-1:0] r_vic_key;
    logic [COUNT_BITS-1:0]   r_vic_cnt;
    logic [IDX_W-1:0]        r_vic_rank;
    logic                    r_free_found;
    logic [IDX_W-1:0]        r_free_idx;
    logic [CNT_W-1:0]        r_fill;

    // ---------------- response register ----------------
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic [VAL_W-1:0]        r_out_rval;
    logic                    r_out_evicted;
    logic signed [KEY_W-1:0] r_out_ekey;

    // ---------------- table RAM ----------------
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    lfuc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    logic signed [KEY_W-1:0] d_key;
    logic [VAL_W-1:0]        d_val;
    logic [COUNT_BITS-1:0]   d_cnt;

    assign d_key = ram_rdata[WORD_W-1 -: KEY_W];
    assign d_val = ram_rdata[COUNT_BITS +: VAL_W];
    assign d_cnt = ram_rdata[COUNT_BITS-1:0];

    // ---------------- shared scan compare unit ----------------
    logic             cmp_live;
    logic             cmp_match;
    logic             cmp_better;
    logic             cmp_free;
    logic [IDX_W-1:0] cmp_rank;

    always_comb begin
        cmp_rank   = r_rank[r_cmp_idx];
        cmp_live   = r_cmp_vld && r_valid[r_cmp_idx];
        cmp_match  = cmp_live && (d_key == r_key);
        cmp_better = cmp_live && (!r_vic_found || (d_cnt < r_vic_cnt) ||
                     ((d_cnt == r_vic_cnt) && (cmp_rank < r_vic_rank)));
        cmp_free   = r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found;
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == SCAN_END) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        in_ready = 1'b0;
        upd_fire = 1'b0;
        case (r_state)
            ST_IDLE:   in_ready = 1'b1;
            ST_SCAN:   ;
            ST_UPDATE: upd_fire = !r_out_valid || o_rsp.ready;
            default:   ;
        endcase
    end

    assign i_req.ready = in_ready;
    assign req_fire    = in_ready && i_req.valid;

    // ---------------- update decision ----------------
    logic [CMPW-1:0]       cap_eff;
    logic [CMPW-1:0]       fill_ext;
    logic [COUNT_BITS-1:0] bumped;
    logic                  do_touch;
    logic [IDX_W-1:0]      touch_idx;
    logic [IDX_W-1:0]      touch_old;
    logic                  do_evict;
    logic                  do_insert;
    logic [IDX_W-1:0]      ins_idx;
    logic                  res_hit;
    logic [VAL_W-1:0]      res_rval;
    logic                  res_evicted;
    logic signed [KEY_W-1:0] res_ekey;

    always_comb begin
        cap_eff  = (CMPW'(r_capacity) > ENT_LIMIT) ? ENT_LIMIT : CMPW'(r_capacity);
        fill_ext = CMPW'(r_fill);
        bumped   = (r_found_cnt == COUNT_MAX) ? r_found_cnt : r_found_cnt + COUNT_ONE;

        ram_we    = 1'b0;
        ram_waddr = r_found_idx;
        ram_wdata = {r_key, r_wval, bumped};
        do_touch  = 1'b0;
        touch_idx = r_found_idx;
        do_evict  = 1'b0;
        do_insert = 1'b0;
        ins_idx   = r_free_idx;

        res_hit     = r_found;
        res_rval    = '0;
        res_evicted = 1'b0;
        res_ekey    = '0;

        case (r_op)
            OP_GET: begin
                if (r_found) begin
                    res_rval  = r_found_val;
                    ram_we    = upd_fire;
                    ram_wdata = {r_key, r_found_val, bumped};
                    do_touch  = 1'b1;
                end
            end
            OP_SET: begin
                if (cap_eff != '0) begin
                    if (r_found) begin
                        ram_we   = upd_fire;
                        do_touch = 1'b1;
                    end else begin
                        // full (or over capacity after a lowered limit): drop the victim, then fill the
                        // lowest free slot, the victim's freed slot included
                        do_evict = r_vic_found && (fill_ext >= cap_eff);
                        if (do_evict && (!r_free_found || (r_vic_idx < r_free_idx))) begin
                            ins_idx = r_vic_idx;
                        end
                        do_insert   = 1'b1;
                        ram_we      = upd_fire;
                        ram_waddr   = ins_idx;
                        ram_wdata   = {r_key, r_wval, COUNT_ONE};
                        do_touch    = 1'b1;
                        touch_idx   = ins_idx;
                        res_evicted = do_evict;
                        if (do_evict) begin
                            res_ekey = r_vic_key;
                        end
                    end
                end
            end
            default: ;
        endcase

        // victim cleared first, the insert may reuse its slot
        n_valid = r_valid;
        if (do_evict) begin
            n_valid[r_vic_idx] = 1'b0;
        end
        if (do_insert) begin
            n_valid[ins_idx] = 1'b1;
        end

        touch_old = r_rank[touch_idx];
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_capacity  <= CAP_RESET;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= IDX_W'(i);
            end
        end else begin
            r_state <= n_state;

            if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end

            // scan address and compare pipeline
            if (req_fire) begin
                r_cnt <= '0;
            end else if ((r_state == ST_SCAN) && (r_cnt != SCAN_END)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_cmp_vld <= (r_state == ST_SCAN) && (r_cnt != SCAN_END);

            if (upd_fire) begin
                r_valid <= n_valid;
            end

            // recency: touched entry goes to the top, those above it slide down
            if (upd_fire && do_touch) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == touch_idx) begin
                        r_rank[i] <= RANK_TOP;
                    end else if (r_rank[i] > touch_old) begin
                        r_rank[i] <= r_rank[i] - IDX_W'(1);
                    end
                end
            end

            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and scan trackers, no reset needed (re-armed on every request)
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt[IDX_W-1:0];

        if (req_fire) begin
            r_op         <= i_req.op;
            r_key        <= i_req.key;
            r_wval       <= i_req.write_value;
            r_found      <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_fill       <= '0;
        end else begin
            if (cmp_live) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (cmp_match) begin
                r_found     <= 1'b1;
                r_found_idx <= r_cmp_idx;
                r_found_val <= d_val;
                r_found_cnt <= d_cnt;
            end
            if (cmp_better) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_cmp_idx;
                r_vic_key   <= d_key;
                r_vic_cnt   <= d_cnt;
                r_vic_rank  <= cmp_rank;
            end
            if (cmp_free) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end

        if (upd_fire) begin
            r_out_hit     <= res_hit;
            r_out_rval    <= res_rval;
            r_out_evicted <= res_evicted;
            r_out_ekey    <= res_ekey;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_rval;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_ekey;

endmodule

`default_nettype wire
